// ----- hdl/bbc_pkg.sv -----
// Shared types and codes for the block buffer cache allocator.
`timescale 1ns / 1ps
package bbc_pkg;

   localparam logic [1:0] CMD_GET        = 2'd0;
   localparam logic [1:0] CMD_RELEASE    = 2'd1;
   localparam logic [1:0] CMD_SET_FLAGS  = 2'd2;
   localparam logic [1:0] CMD_INVALIDATE = 2'd3;

   localparam logic [2:0] ST_HIT          = 3'd0;
   localparam logic [2:0] ST_ALLOCATED    = 3'd1;
   localparam logic [2:0] ST_NONE_FREE    = 3'd2;
   localparam logic [2:0] ST_VICTIM_DIRTY = 3'd3;
   localparam logic [2:0] ST_VICTIM_LOCK  = 3'd4;
   localparam logic [2:0] ST_DONE         = 3'd5;
   localparam logic [2:0] ST_REL_ERROR    = 3'd6;

   localparam logic [7:0] COUNT_MAX = 8'hFF;
   localparam logic [8:0] BUFFERS_USED_RESET = 9'd256;

   typedef struct packed {
      logic [15:0] device;
      logic [15:0] block;
      logic [7:0]  count;
      logic        dirty;
      logic        locked;
      logic        valid;
   } entry_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] index;
      logic       valid;
      logic [7:0] count;
   } result_type;

endpackage

// ----- hdl/bbc_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
module bbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- hdl/bbc_ctrl.sv -----
// Command sequencer: lookup, victim scan, ring update, release, flags, invalidate.
`timescale 1ns / 1ps
module bbc_ctrl #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [1:0]                     req_command,
   input  logic [15:0]                    req_device,
   input  logic [15:0]                    req_block,
   input  logic [7:0]                     req_index,
   input  logic [2:0]                     req_flags,
   input  logic                           csr_valid,
   input  logic [8:0]                     csr_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output bbc_pkg::result_type            rsp_result,
   output logic [$clog2(NUM_ENTRIES)-1:0] raddr,
   output logic                           ent_we,
   output logic [$clog2(NUM_ENTRIES)-1:0] ent_waddr,
   output bbc_pkg::entry_type             ent_wdata,
   input  bbc_pkg::entry_type             ent_rdata,
   output logic                           nxt_we,
   output logic [$clog2(NUM_ENTRIES)-1:0] nxt_waddr,
   output logic [$clog2(NUM_ENTRIES)-1:0] nxt_wdata,
   input  logic [$clog2(NUM_ENTRIES)-1:0] nxt_rdata,
   output logic                           prv_we,
   output logic [$clog2(NUM_ENTRIES)-1:0] prv_waddr,
   output logic [$clog2(NUM_ENTRIES)-1:0] prv_wdata,
   input  logic [$clog2(NUM_ENTRIES)-1:0] prv_rdata
);
   localparam int IW = $clog2(NUM_ENTRIES);
   localparam int CW = $clog2(NUM_ENTRIES + 1);
   localparam logic [IW-1:0] LAST = IW'(NUM_ENTRIES - 1);
   localparam logic [CW-1:0] NUM_C = CW'(NUM_ENTRIES);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LOOK  = 4'd2;
   localparam logic [3:0] S_HIT   = 4'd3;
   localparam logic [3:0] S_VSCAN = 4'd4;
   localparam logic [3:0] S_VDONE = 4'd5;
   localparam logic [3:0] S_MV1   = 4'd6;
   localparam logic [3:0] S_MV2   = 4'd7;
   localparam logic [3:0] S_MV3   = 4'd8;
   localparam logic [3:0] S_MV4   = 4'd9;
   localparam logic [3:0] S_IDXOP = 4'd10;
   localparam logic [3:0] S_INV   = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]          state_ff, state_in;
   logic [8:0]          used_ff, used_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [15:0]         dev_ff, dev_in;
   logic [15:0]         blk_ff, blk_in;
   logic [7:0]          bidx_ff, bidx_in;
   logic [2:0]          flags_ff, flags_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                pend_ff, pend_in;
   logic [IW-1:0]       tag_ff, tag_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic                found_ff, found_in;
   logic [IW-1:0]       best_ff, best_in;
   bbc_pkg::entry_type  bent_ff, bent_in;
   logic [IW-1:0]       bnx_ff, bnx_in;
   logic [IW-1:0]       bpv_ff, bpv_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       mvh_ff, mvh_in;
   logic [IW-1:0]       mvp_ff, mvp_in;
   bbc_pkg::result_type res_ff, res_in;
   bbc_pkg::result_type out_ff, out_in;
   logic                oval_ff, oval_in;

   logic [CW-1:0] n_act;
   logic [15:0]   used_ext;
   logic          req_idx_ok;
   logic          hit;
   logic [1:0]    bad_cur, bad_best;
   logic          cand;

   always_comb begin
      used_ext = 16'(used_ff);
      if (used_ext == 16'd0) begin
         n_act = CW'(1);
      end else if (used_ext > 16'(NUM_ENTRIES)) begin
         n_act = NUM_C;
      end else begin
         n_act = CW'(used_ext);
      end
   end

   assign req_idx_ok = 16'(req_index) < 16'(n_act);
   assign hit = pend_ff && ent_rdata.device != 16'd0 && ent_rdata.device == dev_ff
                && ent_rdata.block == blk_ff;
   assign bad_cur  = {ent_rdata.dirty, ent_rdata.locked};
   assign bad_best = {bent_ff.dirty, bent_ff.locked};
   assign cand = (16'(cur_ff) < 16'(n_act)) && ent_rdata.count == 8'd0
                 && (!found_ff || bad_cur < bad_best);

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = oval_ff;
   assign rsp_result = out_ff;

   always_comb begin
      state_in = state_ff;
      used_in  = csr_valid ? csr_data : used_ff;
      cmd_in   = cmd_ff;
      dev_in   = dev_ff;
      blk_in   = blk_ff;
      bidx_in  = bidx_ff;
      flags_in = flags_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      tag_in   = tag_ff;
      steps_in = steps_ff;
      cur_in   = cur_ff;
      found_in = found_ff;
      best_in  = best_ff;
      bent_in  = bent_ff;
      bnx_in   = bnx_ff;
      bpv_in   = bpv_ff;
      head_in  = head_ff;
      mvh_in   = mvh_ff;
      mvp_in   = mvp_ff;
      res_in   = res_ff;
      out_in   = out_ff;
      oval_in  = oval_ff && !rsp_tready;
      raddr     = cnt_ff[IW-1:0];
      ent_we    = 1'b0;
      ent_waddr = best_ff;
      ent_wdata = bent_ff;
      nxt_we    = 1'b0;
      nxt_waddr = bpv_ff;
      nxt_wdata = bnx_ff;
      prv_we    = 1'b0;
      prv_waddr = bnx_ff;
      prv_wdata = bpv_ff;

      unique case (state_ff)
         S_CLR: begin
            ent_we    = 1'b1;
            ent_waddr = cnt_ff[IW-1:0];
            ent_wdata = '0;
            nxt_we    = 1'b1;
            nxt_waddr = cnt_ff[IW-1:0];
            nxt_wdata = (cnt_ff[IW-1:0] == LAST) ? '0 : cnt_ff[IW-1:0] + IW'(1);
            prv_we    = 1'b1;
            prv_waddr = cnt_ff[IW-1:0];
            prv_wdata = (cnt_ff[IW-1:0] == '0) ? LAST : cnt_ff[IW-1:0] - IW'(1);
            cnt_in    = cnt_ff + CW'(1);
            if (cnt_ff[IW-1:0] == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            raddr = IW'(req_index);
            if (req_tvalid) begin
               cmd_in   = req_command;
               dev_in   = req_device;
               blk_in   = req_block;
               bidx_in  = req_index;
               flags_in = req_flags;
               cnt_in   = '0;
               pend_in  = 1'b0;
               unique case (req_command)
                  bbc_pkg::CMD_GET:        state_in = S_LOOK;
                  bbc_pkg::CMD_INVALIDATE: state_in = S_INV;
                  default: begin
                     if (req_idx_ok) begin
                        state_in = S_IDXOP;
                     end else begin
                        res_in.status = (req_command == bbc_pkg::CMD_RELEASE)
                                        ? bbc_pkg::ST_REL_ERROR : bbc_pkg::ST_DONE;
                        res_in.index  = req_index;
                        res_in.valid  = 1'b0;
                        res_in.count  = 8'd0;
                        state_in = S_OUT;
                     end
                  end
               endcase
            end
         end
         S_LOOK: begin
            raddr = (cnt_ff < n_act) ? cnt_ff[IW-1:0] : head_ff;
            if (hit) begin
               best_in  = tag_ff;
               bent_in  = ent_rdata;
               state_in = S_HIT;
            end else if (cnt_ff < n_act) begin
               tag_in  = cnt_ff[IW-1:0];
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cur_in   = head_ff;
                  steps_in = '0;
                  found_in = 1'b0;
                  state_in = S_VSCAN;
               end
            end
         end
         S_HIT: begin
            ent_we = 1'b1;
            ent_wdata = bent_ff;
            if (bent_ff.count != bbc_pkg::COUNT_MAX) begin
               ent_wdata.count = bent_ff.count + 8'd1;
            end
            res_in.status = bbc_pkg::ST_HIT;
            res_in.index  = 8'(best_ff);
            res_in.valid  = bent_ff.valid;
            res_in.count  = ent_wdata.count;
            state_in = S_OUT;
         end
         S_VSCAN: begin
            raddr = nxt_rdata;
            if (cand) begin
               best_in  = cur_ff;
               bent_in  = ent_rdata;
               bnx_in   = nxt_rdata;
               bpv_in   = prv_rdata;
               found_in = 1'b1;
            end
            cur_in   = nxt_rdata;
            steps_in = steps_ff + CW'(1);
            if ((cand && bad_cur == 2'd0) || steps_ff == CW'(NUM_ENTRIES - 1)) begin
               state_in = S_VDONE;
            end
         end
         S_VDONE: begin
            res_in.index = 8'(best_ff);
            res_in.valid = bent_ff.valid;
            res_in.count = bent_ff.count;
            state_in = S_OUT;
            if (!found_ff) begin
               res_in = '0;
               res_in.status = bbc_pkg::ST_NONE_FREE;
            end else if (bent_ff.dirty) begin
               res_in.status = bbc_pkg::ST_VICTIM_DIRTY;
            end else if (bent_ff.locked) begin
               res_in.status = bbc_pkg::ST_VICTIM_LOCK;
            end else begin
               ent_we = 1'b1;
               ent_wdata.device = dev_ff;
               ent_wdata.block  = blk_ff;
               ent_wdata.count  = 8'd1;
               ent_wdata.dirty  = 1'b0;
               ent_wdata.locked = 1'b0;
               ent_wdata.valid  = 1'b0;
               state_in = S_MV1;
            end
         end
         S_MV1: begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
            mvh_in  = (head_ff == best_ff) ? bnx_ff : head_ff;
            head_in = mvh_in;
            state_in = S_MV2;
         end
         S_MV2: begin
            raddr = mvh_ff;
            state_in = S_MV3;
         end
         S_MV3: begin
            nxt_we    = 1'b1;
            nxt_waddr = best_ff;
            nxt_wdata = mvh_ff;
            prv_we    = 1'b1;
            prv_waddr = best_ff;
            prv_wdata = prv_rdata;
            mvp_in    = prv_rdata;
            state_in  = S_MV4;
         end
         S_MV4: begin
            nxt_we    = 1'b1;
            nxt_waddr = mvp_ff;
            nxt_wdata = best_ff;
            prv_we    = 1'b1;
            prv_waddr = mvh_ff;
            prv_wdata = best_ff;
            res_in.status = bbc_pkg::ST_ALLOCATED;
            res_in.index  = 8'(best_ff);
            res_in.valid  = 1'b0;
            res_in.count  = 8'd1;
            state_in = S_OUT;
         end
         S_IDXOP: begin
            ent_waddr = IW'(bidx_ff);
            ent_wdata = ent_rdata;
            res_in.index = bidx_ff;
            res_in.valid = ent_rdata.valid;
            res_in.status = bbc_pkg::ST_DONE;
            if (cmd_ff == bbc_pkg::CMD_RELEASE) begin
               if (ent_rdata.count == 8'd0) begin
                  res_in.status = bbc_pkg::ST_REL_ERROR;
                  res_in.count  = 8'd0;
               end else begin
                  ent_we = 1'b1;
                  ent_wdata.count = ent_rdata.count - 8'd1;
                  res_in.count = ent_wdata.count;
               end
            end else begin
               ent_we = 1'b1;
               {ent_wdata.dirty, ent_wdata.locked, ent_wdata.valid} = flags_ff;
               res_in.valid = flags_ff[0];
               res_in.count = ent_rdata.count;
            end
            state_in = S_OUT;
         end
         S_INV: begin
            ent_waddr = tag_ff;
            ent_wdata = ent_rdata;
            ent_wdata.valid = 1'b0;
            ent_wdata.dirty = 1'b0;
            ent_we = pend_ff && ent_rdata.device == dev_ff;
            if (cnt_ff < n_act) begin
               tag_in  = cnt_ff[IW-1:0];
               pend_in = 1'b1;
               cnt_in  = cnt_ff + CW'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  res_in = '0;
                  res_in.status = bbc_pkg::ST_DONE;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!oval_ff || rsp_tready) begin
               out_in   = res_ff;
               oval_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         used_ff  <= bbc_pkg::BUFFERS_USED_RESET;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
         head_ff  <= '0;
         oval_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         head_ff  <= head_in;
         oval_ff  <= oval_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      dev_ff   <= dev_in;
      blk_ff   <= blk_in;
      bidx_ff  <= bidx_in;
      flags_ff <= flags_in;
      tag_ff   <= tag_in;
      steps_ff <= steps_in;
      cur_ff   <= cur_in;
      best_ff  <= best_in;
      bent_ff  <= bent_in;
      bnx_ff   <= bnx_in;
      bpv_ff   <= bpv_in;
      mvh_ff   <= mvh_in;
      mvp_ff   <= mvp_in;
      res_ff   <= res_in;
      out_ff   <= out_in;
   end
endmodule

// ----- hdl/block_buffer_cache_allocator.sv -----
// Top level of the block buffer cache allocator.
// One command is worked on at a time; the next request beat is taken as soon
// as the previous result sits in the output register. A get hit and a get
// miss both run a lookup that reads one entry per cycle from the entry memory;
// a get miss then walks the ring one step per cycle through the link memories,
// up to NUM_ENTRIES steps, before the claim and ring update. After reset a
// clearing pass initializes every entry of the memories before the first
// request beat is accepted; configuration writes are always accepted.
`timescale 1ns / 1ps
module block_buffer_cache_allocator #(
   parameter int NUM_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // device[15:0], block_number[31:16], buffer_index[39:32],
   // new_dirty[40], new_locked[41], new_valid[42], zero fill
   input  logic [47:0] req_tdata,
   // command[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // entry_index[7:0], entry_valid[8], entry_count[16:9], zero fill
   output logic [23:0] rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);
   localparam int IW = $clog2(NUM_ENTRIES);
   localparam int EW = $bits(bbc_pkg::entry_type);

   logic [IW-1:0]       raddr;
   logic                ent_we, nxt_we, prv_we;
   logic [IW-1:0]       ent_waddr, nxt_waddr, prv_waddr;
   bbc_pkg::entry_type  ent_wdata, ent_rdata;
   logic [EW-1:0]       ent_rbits;
   logic [IW-1:0]       nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
   bbc_pkg::result_type result;

   assign csr_ready = 1'b1;
   assign ent_rdata = bbc_pkg::entry_type'(ent_rbits);
   assign rsp_tdata = {7'd0, result.count, result.valid, result.index};
   assign rsp_tuser = result.status;

   bbc_ctrl #(.NUM_ENTRIES(NUM_ENTRIES)) u_ctrl (
      .clock, .reset,
      .req_tvalid, .req_tready,
      .req_command (req_tuser),
      .req_device  (req_tdata[15:0]),
      .req_block   (req_tdata[31:16]),
      .req_index   (req_tdata[39:32]),
      .req_flags   ({req_tdata[40], req_tdata[41], req_tdata[42]}),
      .csr_valid, .csr_data,
      .rsp_tvalid, .rsp_tready,
      .rsp_result  (result),
      .raddr,
      .ent_we, .ent_waddr, .ent_wdata, .ent_rdata,
      .nxt_we, .nxt_waddr, .nxt_wdata, .nxt_rdata,
      .prv_we, .prv_waddr, .prv_wdata, .prv_rdata
   );

   bbc_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_entry_ram (
      .clock, .we(ent_we), .waddr(ent_waddr), .wdata(EW'(ent_wdata)),
      .raddr, .rdata(ent_rbits)
   );

   bbc_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_next_ram (
      .clock, .we(nxt_we), .waddr(nxt_waddr), .wdata(nxt_wdata),
      .raddr, .rdata(nxt_rdata)
   );

   bbc_ram #(.WIDTH(IW), .DEPTH(NUM_ENTRIES)) u_prev_ram (
      .clock, .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
      .raddr, .rdata(prv_rdata)
   );
endmodule

// ----- hdl/bbc_checker.sv -----
// Port-level checks for the block buffer cache allocator, with bind.
`timescale 1ns / 1ps
module bbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_none_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bbc_pkg::ST_NONE_FREE |-> rsp_tdata == 24'd0)
      else $error("none free with nonzero payload");

   a_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bbc_pkg::ST_ALLOCATED |-> rsp_tdata[16:8] == 9'd2)
      else $error("allocated entry not count one and invalid");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == bbc_pkg::ST_HIT |-> rsp_tdata[16:9] != 8'd0)
      else $error("hit with zero count");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request beat taken while a command is in flight");
endmodule

bind block_buffer_cache_allocator bbc_checker u_bbc_checker (
   .clock, .reset, .req_tvalid, .req_tready,
   .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
);

// ----- sim/tb_block_buffer_cache_allocator.sv -----
// Self-checking testbench for the block buffer cache allocator: directed and random commands.
`timescale 1ns / 1ps
module tb_block_buffer_cache_allocator;

   localparam int DEPTH = 256;
   localparam int STALL_LIMIT = 6000;

   class cache_scoreboard;
      logic [15:0] tag_dev [DEPTH];
      logic [15:0] tag_blk [DEPTH];
      logic [7:0]  refs [DEPTH];
      logic        dirty [DEPTH];
      logic        locked [DEPTH];
      logic        valid [DEPTH];
      int          nxt [DEPTH];
      int          prv [DEPTH];
      int          head;
      logic [8:0]  used;
      bbc_pkg::result_type pending_results[$];
      int          errors;
      int          checked;

      function void clear();
         for (int i = 0; i < DEPTH; i++) begin
            tag_dev[i] = 16'd0; tag_blk[i] = 16'd0; refs[i] = 8'd0;
            dirty[i] = 1'b0; locked[i] = 1'b0; valid[i] = 1'b0;
            nxt[i] = (i + 1) % DEPTH;
            prv[i] = (i + DEPTH - 1) % DEPTH;
         end
         head = 0;
         used = bbc_pkg::BUFFERS_USED_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function int active();
         if (used < 1) return 1;
         if (used > DEPTH) return DEPTH;
         return int'(used);
      endfunction

      function int badness(int e);
         return int'(dirty[e]) * 2 + int'(locked[e]);
      endfunction

      function void to_tail(int e);
         int nx, pv;
         nx = nxt[e]; pv = prv[e];
         nxt[pv] = nx; prv[nx] = pv;
         if (head == e) head = nx;
         pv = prv[head];
         nxt[e] = head; prv[e] = pv;
         nxt[pv] = e; prv[head] = e;
      endfunction

      function void push(logic [2:0] st, int idx, logic v, logic [7:0] c);
         bbc_pkg::result_type r;
         r.status = st; r.index = idx[7:0]; r.valid = v; r.count = c;
         pending_results.push_back(r);
      endfunction

      function void note_request(logic [1:0] cmd, logic [15:0] dev, logic [15:0] blk,
                                 logic [7:0] idx, logic d, logic l, logic v);
         int n, e, best;
         bit found;
         n = active();
         found = 0;
         best = 0;
         case (cmd)
            bbc_pkg::CMD_GET: begin
               for (int i = 0; i < n; i++)
                  if (tag_dev[i] != 0 && tag_dev[i] == dev && tag_blk[i] == blk) begin
                     if (refs[i] != bbc_pkg::COUNT_MAX) refs[i]++;
                     push(bbc_pkg::ST_HIT, i, valid[i], refs[i]);
                     return;
                  end
               e = head;
               for (int s = 0; s < DEPTH; s++) begin
                  if (e < n && refs[e] == 0)
                     if (!found || badness(e) < badness(best)) begin
                        best = e;
                        found = 1;
                        if (badness(e) == 0) break;
                     end
                  e = nxt[e];
               end
               if (!found) push(bbc_pkg::ST_NONE_FREE, 0, 1'b0, 8'd0);
               else if (dirty[best])
                  push(bbc_pkg::ST_VICTIM_DIRTY, best, valid[best], refs[best]);
               else if (locked[best])
                  push(bbc_pkg::ST_VICTIM_LOCK, best, valid[best], refs[best]);
               else begin
                  refs[best] = 8'd1; dirty[best] = 1'b0; valid[best] = 1'b0;
                  tag_dev[best] = dev; tag_blk[best] = blk;
                  to_tail(best);
                  push(bbc_pkg::ST_ALLOCATED, best, 1'b0, 8'd1);
               end
            end
            bbc_pkg::CMD_RELEASE: begin
               if (idx >= n) push(bbc_pkg::ST_REL_ERROR, int'(idx), 1'b0, 8'd0);
               else if (refs[idx] == 0)
                  push(bbc_pkg::ST_REL_ERROR, int'(idx), valid[idx], 8'd0);
               else begin
                  refs[idx]--;
                  push(bbc_pkg::ST_DONE, int'(idx), valid[idx], refs[idx]);
               end
            end
            bbc_pkg::CMD_SET_FLAGS: begin
               if (idx >= n) push(bbc_pkg::ST_DONE, int'(idx), 1'b0, 8'd0);
               else begin
                  dirty[idx] = d; locked[idx] = l; valid[idx] = v;
                  push(bbc_pkg::ST_DONE, int'(idx), v, refs[idx]);
               end
            end
            default: begin
               for (int i = 0; i < n; i++)
                  if (tag_dev[i] == dev) begin
                     valid[i] = 1'b0;
                     dirty[i] = 1'b0;
                  end
               push(bbc_pkg::ST_DONE, 0, 1'b0, 8'd0);
            end
         endcase
      endfunction

      function void check_result(logic [2:0] st, logic [7:0] idx, logic v, logic [7:0] c);
         bbc_pkg::result_type r;
         checked++;
         if (pending_results.size() == 0) begin
            $error("unexpected result beat: status %0d index %0d", st, idx);
            errors++;
            return;
         end
         r = pending_results.pop_front();
         if (st !== r.status) begin
            $error("status: expected %0d, got %0d", r.status, st);
            errors++;
         end
         if (idx !== r.index) begin
            $error("entry_index: expected %0d, got %0d", r.index, idx);
            errors++;
         end
         if (v !== r.valid) begin
            $error("entry_valid: expected %0d, got %0d", r.valid, v);
            errors++;
         end
         if (c !== r.count) begin
            $error("entry_count: expected %0d, got %0d", r.count, c);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = bbc_pkg::CMD_GET;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [8:0]  csr_data = '0;

   cache_scoreboard sb;
   int send_idle = 33;
   int recv_idle = 77;
   int sent = 0;
   int stall_cycles = 0;

   block_buffer_cache_allocator #(.NUM_ENTRIES(DEPTH)) dut (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tuser, rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[16:9]);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_cmd(logic [1:0] cmd, logic [15:0] dev, logic [15:0] blk,
                           logic [7:0] idx, logic d, logic l, logic v);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, v, l, d, idx, blk, dev};
      forever begin
         @(negedge clock);
         if (req_tready) break;
         @(posedge clock);
      end
      @(posedge clock);
      sb.note_request(cmd, dev, blk, idx, d, l, v);
      sent++;
      if (sent == 480) begin send_idle = 77; recv_idle = 33; end
      if (sent == 960) begin send_idle = 0; recv_idle = 0; end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_used(logic [8:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
         @(posedge clock);
      end
      @(posedge clock);
      csr_valid <= 1'b0;
      sb.used = value;
   endtask

   task automatic random_cmd();
      int n, pick;
      logic [15:0] dev, blk;
      logic [7:0] idx;
      n = sb.active();
      pick = $urandom_range(99);
      dev = ($urandom_range(19) == 0) ? 16'd0 :
            ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3, 1));
      blk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
      idx = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(n - 1));
      if (pick < 45)
         send_cmd(bbc_pkg::CMD_GET, dev, blk, 8'($urandom),
                  1'($urandom), 1'($urandom), 1'($urandom));
      else if (pick < 72)
         send_cmd(bbc_pkg::CMD_RELEASE, 16'($urandom), 16'($urandom), idx,
                  1'($urandom), 1'($urandom), 1'($urandom));
      else if (pick < 92)
         send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'($urandom), 16'($urandom), idx,
                  $urandom_range(3) == 0, $urandom_range(3) == 0, 1'($urandom));
      else
         send_cmd(bbc_pkg::CMD_INVALIDATE, dev, 16'($urandom), idx,
                  1'($urandom), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      logic [8:0] settings [10];
      settings = '{9'd16, 9'd1, 9'd0, 9'd511, 9'd8, 9'd256, 9'd3, 9'd300, 9'd2, 9'd64};
      sb = new();
      sb.clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: full table
      send_cmd(bbc_pkg::CMD_GET, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_RELEASE, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_RELEASE, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_RELEASE, 16'd0, 16'd0, 8'd255, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd255, 1'b1, 1'b1, 1'b1);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd0, 1'b1, 1'b0, 1'b1);
      send_cmd(bbc_pkg::CMD_INVALIDATE, 16'hFFFF, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      // directed: four entries, victims and errors
      write_used(9'd4);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd2, 1'b1, 1'b1, 1'b1);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd3, 1'b0, 1'b1, 1'b1);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd1, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd2, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd3, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd2, 1'b0, 1'b1, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd3, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd3, 1'b0, 1'b0, 1'b1);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd2, 1'b0, 1'b0, 1'b1);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd4, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd5, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_GET, 16'd7, 16'd6, 8'd0, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_RELEASE, 16'd0, 16'd0, 8'd200, 1'b0, 1'b0, 1'b0);
      send_cmd(bbc_pkg::CMD_SET_FLAGS, 16'd0, 16'd0, 8'd200, 1'b1, 1'b1, 1'b1);
      send_cmd(bbc_pkg::CMD_INVALIDATE, 16'd0, 16'd0, 8'd0, 1'b0, 1'b0, 1'b0);

      foreach (settings[p]) begin
         write_used(settings[p]);
         if (settings[p] == 9'd2)
            repeat (260)
               send_cmd(bbc_pkg::CMD_GET, 16'd9, 16'd9, 8'd0, 1'b0, 1'b0, 1'b0);
         repeat (115) random_cmd();
      end
      drain();
      repeat (30) @(posedge clock);

      $display("Ran %0d commands over ten table sizes from 1 to the full depth and beyond,",
               sent);
      $display("with %0d result beats checked under three idling patterns.", sb.checked);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
